// ===== sv/owbm_pkg.sv =====
// Package for the one-wire bus master: constants, codes and payload types.
`timescale 1ns / 1ps
package owbm_pkg;

   localparam int PORT_COUNT    = 16;
   localparam int DIVIDER_WIDTH = 16;

   localparam logic [15:0] DIV_MASK  = 16'((32'd1 << DIVIDER_WIDTH) - 32'd1);
   localparam logic [15:0] PORT_MASK = 16'((32'd1 << PORT_COUNT) - 32'd1);

   // register reset values
   localparam logic [15:0] DIV_NORMAL_RST    = 16'(624 / 2);
   localparam logic [15:0] DIV_OVERDRIVE_RST = 16'(124 / 2);
   localparam logic [7:0]  RESET_LOW_RST     = 8'd96;
   localparam logic [7:0]  PRESENCE_RST      = 8'd110;
   localparam logic [7:0]  RESET_TOTAL_RST   = 8'd192;
   localparam logic [7:0]  SLOT_LOW_ONE_RST  = 8'd1;
   localparam logic [7:0]  SLOT_SAMPLE_RST   = 8'd3;
   localparam logic [7:0]  SLOT_TOTAL_RST    = 8'd14;

   // control word bit positions
   localparam int CTL_DATA      = 0;
   localparam int CTL_RESET     = 1;
   localparam int CTL_OVERDRIVE = 2;
   localparam int CTL_START     = 3;
   localparam int CTL_POWER     = 4;
   localparam int CTL_IRQ_PEND  = 6;
   localparam int CTL_IRQ_EN    = 7;

   typedef enum logic [1:0] {
      OP_IDLE  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CSR_DIV_NORMAL    = 3'd0,
      CSR_DIV_OVERDRIVE = 3'd1,
      CSR_RESET_LOW     = 3'd2,
      CSR_PRESENCE      = 3'd3,
      CSR_RESET_TOTAL   = 3'd4,
      CSR_SLOT_LOW_ONE  = 3'd5,
      CSR_SLOT_SAMPLE   = 3'd6,
      CSR_SLOT_TOTAL    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] write_data;
      logic        line_level;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        drive_low;
      logic [3:0]  port_index;
      logic [15:0] strong_pullup;
      logic        interrupt;
   } rsp_type;

endpackage

// ===== sv/onewire_bus_master.sv =====
// One-wire bus master: control register, prescaler, cycle timer and response register.
`timescale 1ns / 1ps
// Each request is one system clock of the bus master: an idle clock, a control
// register write or a control register read. One request is taken per cycle while
// no response waits unaccepted, and each is answered by exactly one response from
// the response register in the next cycle; a new request is taken in the same
// cycle that a waiting response leaves. Timing advances only on accepted requests.
// A write with the start bit set runs a reset/presence cycle or one data slot of
// total ticks, the prescaler dividing accepted requests down to ticks (a divider of 0
// counts as 1, a total of 0 or 1 as one tick); busy reads back set until it ends, after
// which the pending interrupt is raised. Reading the register clears the interrupt.
module onewire_bus_master
   import owbm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data,
   input  logic          csr_we,
   input  csr_index_type csr_addr,
   input  logic [15:0]   csr_wdata
);

   // configuration
   logic [15:0] div_normal_ff, div_overdrive_ff;
   logic [7:0]  reset_low_ff, presence_ff, reset_total_ff;
   logic [7:0]  slot_low_one_ff, slot_sample_ff, slot_total_ff;

   // bus state
   logic [15:0] prescale_count_ff, prescale_count_in;
   logic [7:0]  tick_count_ff, tick_count_in;
   logic        busy_ff, busy_in;
   logic        reset_mode_ff, reset_mode_in;
   logic        overdrive_mode_ff, overdrive_mode_in;
   logic        data_bit_ff, data_bit_in;
   logic        slot_value_ff, slot_value_in;
   logic [3:0]  selected_port_ff, selected_port_in;
   logic [16:0] power_bits_ff, power_bits_in;
   logic        irq_pending_ff, irq_pending_in;
   logic        irq_enable_ff, irq_enable_in;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_normal_ff    <= DIV_NORMAL_RST;
         div_overdrive_ff <= DIV_OVERDRIVE_RST;
         reset_low_ff     <= RESET_LOW_RST;
         presence_ff      <= PRESENCE_RST;
         reset_total_ff   <= RESET_TOTAL_RST;
         slot_low_one_ff  <= SLOT_LOW_ONE_RST;
         slot_sample_ff   <= SLOT_SAMPLE_RST;
         slot_total_ff    <= SLOT_TOTAL_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_DIV_NORMAL:    div_normal_ff    <= csr_wdata;
            CSR_DIV_OVERDRIVE: div_overdrive_ff <= csr_wdata;
            CSR_RESET_LOW:     reset_low_ff     <= csr_wdata[7:0];
            CSR_PRESENCE:      presence_ff      <= csr_wdata[7:0];
            CSR_RESET_TOTAL:   reset_total_ff   <= csr_wdata[7:0];
            CSR_SLOT_LOW_ONE:  slot_low_one_ff  <= csr_wdata[7:0];
            CSR_SLOT_SAMPLE:   slot_sample_ff   <= csr_wdata[7:0];
            CSR_SLOT_TOTAL:    slot_total_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [15:0] div_sel;
      logic [15:0] pc_inc;
      logic [7:0]  tick_inc;
      logic [7:0]  sample;
      logic [7:0]  total;
      logic [3:0]  port;
      logic [31:0] image;
      logic [31:0] rd;
      logic        line_low;

      prescale_count_in = prescale_count_ff;
      tick_count_in     = tick_count_ff;
      busy_in           = busy_ff;
      reset_mode_in     = reset_mode_ff;
      overdrive_mode_in = overdrive_mode_ff;
      data_bit_in       = data_bit_ff;
      slot_value_in     = slot_value_ff;
      selected_port_in  = selected_port_ff;
      power_bits_in     = power_bits_ff;
      irq_pending_in    = irq_pending_ff;
      irq_enable_in     = irq_enable_ff;
      rd                = '0;
      port              = req_data.write_data[11:8];

      image                = '0;
      image[CTL_DATA]      = data_bit_ff;
      image[CTL_RESET]     = reset_mode_ff;
      image[CTL_OVERDRIVE] = overdrive_mode_ff;
      image[CTL_START]     = busy_ff;
      image[CTL_POWER]     = power_bits_ff[0];
      image[CTL_IRQ_PEND]  = irq_pending_ff;
      image[CTL_IRQ_EN]    = irq_enable_ff;
      image[11:8]          = selected_port_ff;
      image[31:16]         = power_bits_ff[16:1];

      div_sel = (overdrive_mode_ff ? div_overdrive_ff : div_normal_ff) & DIV_MASK;
      if (div_sel == '0) begin
         div_sel = 16'd1;
      end
      pc_inc   = (prescale_count_ff + 16'd1) & DIV_MASK;
      tick_inc = tick_count_ff + 8'd1;
      sample   = reset_mode_ff ? presence_ff : slot_sample_ff;
      total    = reset_mode_ff ? reset_total_ff : slot_total_ff;

      if (accept) begin
         case (req_data.operation)
            OP_READ: begin
               rd             = image;
               irq_pending_in = 1'b0;
            end
            OP_WRITE: begin
               // writes are dropped while a bus cycle runs
               if (!busy_ff) begin
                  irq_enable_in = req_data.write_data[CTL_IRQ_EN];
                  if ({1'b0, port} >= 5'(PORT_COUNT)) begin
                     port = 4'(PORT_COUNT - 1);
                  end
                  selected_port_in  = port;
                  power_bits_in     = {req_data.write_data[31:16] & PORT_MASK,
                                       req_data.write_data[CTL_POWER]};
                  overdrive_mode_in = req_data.write_data[CTL_OVERDRIVE];
                  if (req_data.write_data[CTL_START]) begin
                     busy_in           = 1'b1;
                     reset_mode_in     = req_data.write_data[CTL_RESET];
                     slot_value_in     = req_data.write_data[CTL_DATA];
                     data_bit_in       = req_data.write_data[CTL_DATA];
                     tick_count_in     = '0;
                     prescale_count_in = '0;
                     irq_pending_in    = 1'b0;
                  end
               end
            end
            default: ;
         endcase

         if (busy_ff) begin
            if (pc_inc != '0 && pc_inc < div_sel) begin
               prescale_count_in = pc_inc;
            end else begin
               prescale_count_in = '0;
               tick_count_in     = tick_inc;
               if (tick_inc == sample && sample < total) begin
                  data_bit_in = req_data.line_level;
               end
               if (tick_inc >= total) begin
                  busy_in        = 1'b0;
                  irq_pending_in = 1'b1;
                  tick_count_in  = '0;
               end
            end
         end
      end

      if (!busy_in) begin
         line_low = 1'b0;
      end else if (reset_mode_in) begin
         line_low = tick_count_in < reset_low_ff;
      end else if (slot_value_in) begin
         line_low = tick_count_in < slot_low_one_ff;
      end else begin
         // write-0 releases one tick before the slot ends
         line_low = ({1'b0, tick_count_in} + 9'd1) < {1'b0, slot_total_ff};
      end

      rsp_in.read_data     = rd;
      rsp_in.drive_low     = line_low;
      rsp_in.port_index    = selected_port_in;
      rsp_in.strong_pullup = power_bits_in[16:1] |
                             (16'(power_bits_in[0]) << selected_port_in);
      rsp_in.interrupt     = irq_pending_in && irq_enable_in;

      rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_count_ff <= '0;
         tick_count_ff     <= '0;
         busy_ff           <= 1'b0;
         reset_mode_ff     <= 1'b0;
         overdrive_mode_ff <= 1'b0;
         data_bit_ff       <= 1'b0;
         slot_value_ff     <= 1'b0;
         selected_port_ff  <= '0;
         power_bits_ff     <= '0;
         irq_pending_ff    <= 1'b0;
         irq_enable_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         prescale_count_ff <= prescale_count_in;
         tick_count_ff     <= tick_count_in;
         busy_ff           <= busy_in;
         reset_mode_ff     <= reset_mode_in;
         overdrive_mode_ff <= overdrive_mode_in;
         data_bit_ff       <= data_bit_in;
         slot_value_ff     <= slot_value_in;
         selected_port_ff  <= selected_port_in;
         power_bits_ff     <= power_bits_in;
         irq_pending_ff    <= irq_pending_in;
         irq_enable_ff     <= irq_enable_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTH
   // timer is parked at zero whenever no bus cycle runs
   a_idle_timer: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (tick_count_ff == '0 && prescale_count_ff == '0))
      else $error("timer not parked while idle");

   // the line is only pulled low inside a bus cycle
   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.drive_low) |-> busy_ff)
      else $error("drive_low outside a bus cycle");

   a_irq_gated: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.interrupt) |-> (irq_enable_ff && irq_pending_ff))
      else $error("interrupt without enable and pending");

   a_start: assert property (@(posedge clock) disable iff (reset)
      (accept && !busy_ff && req_data.operation == OP_WRITE &&
       req_data.write_data[CTL_START]) |=> busy_ff)
      else $error("start request did not begin a bus cycle");
`endif

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the one-wire bus master: request stimulus, response prediction.
`timescale 1ns / 1ps
module tb;
   import owbm_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_COUNT = 12;
   localparam int PHASE_ITEMS = 55;

   typedef logic [15:0] reg_set_type [8];
   typedef enum {SPEED_ANY, SPEED_OVERDRIVE, SPEED_NORMAL} speed_pick_type;

   // predicts the response of every accepted request and checks the responses in order
   class bus_master_model;
      logic [15:0] div_normal, div_overdrive;
      logic [7:0]  reset_low, presence_tick, reset_total;
      logic [7:0]  slot_low_one, slot_sample, slot_total;
      logic [15:0] prescale;
      logic [7:0]  ticks;
      logic [3:0]  port;
      logic [16:0] power;
      bit          busy, reset_mode, overdrive, data_bit;
      bit          irq_pending, irq_enable, slot_one;
      rsp_type     expected_rsp[$];
      int          errors;
      int          rsp_seen;

      function new();
         div_normal    = DIV_NORMAL_RST;
         div_overdrive = DIV_OVERDRIVE_RST;
         reset_low     = RESET_LOW_RST;
         presence_tick = PRESENCE_RST;
         reset_total   = RESET_TOTAL_RST;
         slot_low_one  = SLOT_LOW_ONE_RST;
         slot_sample   = SLOT_SAMPLE_RST;
         slot_total    = SLOT_TOTAL_RST;
         prescale      = '0;
         ticks         = '0;
         port          = '0;
         power         = '0;
         busy          = 1'b0;
         reset_mode    = 1'b0;
         overdrive     = 1'b0;
         data_bit      = 1'b0;
         irq_pending   = 1'b0;
         irq_enable    = 1'b0;
         slot_one      = 1'b0;
         errors        = 0;
         rsp_seen      = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [15:0] v);
         case (idx)
            CSR_DIV_NORMAL:    div_normal = v;
            CSR_DIV_OVERDRIVE: div_overdrive = v;
            CSR_RESET_LOW:     reset_low = v[7:0];
            CSR_PRESENCE:      presence_tick = v[7:0];
            CSR_RESET_TOTAL:   reset_total = v[7:0];
            CSR_SLOT_LOW_ONE:  slot_low_one = v[7:0];
            CSR_SLOT_SAMPLE:   slot_sample = v[7:0];
            CSR_SLOT_TOTAL:    slot_total = v[7:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      function void take_request(req_type r);
         rsp_type     o;
         bit          was_busy;
         logic [15:0] div, pull;
         logic [7:0]  sample_at, total;
         logic [3:0]  p;
         was_busy = busy;
         o = '0;
         if (r.operation == OP_READ) begin
            // image is taken before this clock's update
            o.read_data[CTL_DATA]      = data_bit;
            o.read_data[CTL_RESET]     = reset_mode;
            o.read_data[CTL_OVERDRIVE] = overdrive;
            o.read_data[CTL_START]     = busy;
            o.read_data[CTL_POWER]     = power[0];
            o.read_data[CTL_IRQ_PEND]  = irq_pending;
            o.read_data[CTL_IRQ_EN]    = irq_enable;
            o.read_data[11:8]          = port;
            o.read_data[31:16]         = power[16:1];
            irq_pending = 1'b0;
         end else if (r.operation == OP_WRITE && !busy) begin
            irq_enable = r.write_data[CTL_IRQ_EN];
            p = r.write_data[11:8];
            if (int'(p) >= PORT_COUNT)
               p = 4'(PORT_COUNT - 1);
            port = p;
            power = {r.write_data[31:16] & PORT_MASK, r.write_data[CTL_POWER]};
            overdrive = r.write_data[CTL_OVERDRIVE];
            if (r.write_data[CTL_START]) begin
               busy        = 1'b1;
               reset_mode  = r.write_data[CTL_RESET];
               slot_one    = r.write_data[CTL_DATA];
               data_bit    = slot_one;
               ticks       = '0;
               prescale    = '0;
               irq_pending = 1'b0;
            end
         end
         if (was_busy && busy) begin
            div = (overdrive ? div_overdrive : div_normal) & DIV_MASK;
            if (div == 16'd0)
               div = 16'd1;
            prescale = (prescale + 16'd1) & DIV_MASK;
            if (prescale == 16'd0 || prescale >= div) begin
               prescale  = '0;
               ticks     = ticks + 8'd1;
               sample_at = reset_mode ? presence_tick : slot_sample;
               total     = reset_mode ? reset_total : slot_total;
               if (ticks == sample_at && sample_at < total)
                  data_bit = r.line_level;
               if (ticks >= total) begin
                  busy        = 1'b0;
                  irq_pending = 1'b1;
                  ticks       = '0;
               end
            end
         end
         pull = power[16:1];
         if (power[0])
            pull[port] = 1'b1;
         if (busy) begin
            if (reset_mode)
               o.drive_low = ticks < reset_low;
            else if (slot_one)
               o.drive_low = ticks < slot_low_one;
            else
               o.drive_low = (9'(ticks) + 9'd1) < 9'(slot_total);
         end
         o.port_index    = port;
         o.strong_pullup = pull;
         o.interrupt     = irq_pending & irq_enable;
         expected_rsp.push_back(o);
      endfunction

      task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
         $display("mismatch at response %0d, %s: got %h, expected %h",
                  rsp_seen, field, got, want);
         errors++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         rsp_seen++;
         if (expected_rsp.size() == 0) begin
            report_mismatch("response with no request", got.read_data, '0);
            return;
         end
         want = expected_rsp.pop_front();
         if (got.read_data !== want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
         if (got.drive_low !== want.drive_low)
            report_mismatch("drive_low", 32'(got.drive_low), 32'(want.drive_low));
         if (got.port_index !== want.port_index)
            report_mismatch("port_index", 32'(got.port_index), 32'(want.port_index));
         if (got.strong_pullup !== want.strong_pullup)
            report_mismatch("strong_pullup", 32'(got.strong_pullup),
                            32'(want.strong_pullup));
         if (got.interrupt !== want.interrupt)
            report_mismatch("interrupt", 32'(got.interrupt), 32'(want.interrupt));
      endtask
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_type       req_data = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_data;
   logic          csr_we = 1'b0;
   csr_index_type csr_addr = CSR_DIV_NORMAL;
   logic [15:0]   csr_wdata = '0;

   bus_master_model master_model = new();
   int  send_calm = 0;
   int  sink_calm = 0;
   int  idle_cycles = 0;
   bit  hold_off_wanted = 1'b0;
   bit  hold_off_done = 1'b0;
   speed_pick_type speed_pick = SPEED_ANY;

   onewire_bus_master dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // mostly back to back, some short gaps, a few long ones, now and then a calm stretch
   function automatic int pick_gap(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 199);
      if (roll < 2) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 120)
         return 0;
      if (roll < 180)
         return $urandom_range(1, 3);
      if (roll < 196)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] ctl_word(bit data, bit rst, bit ovd, bit start, bit pwr,
                                            bit irq_en, logic [3:0] port,
                                            logic [15:0] mask);
      logic [31:0] w;
      w = '0;
      w[CTL_DATA]      = data;
      w[CTL_RESET]     = rst;
      w[CTL_OVERDRIVE] = ovd;
      w[CTL_START]     = start;
      w[CTL_POWER]     = pwr;
      w[CTL_IRQ_EN]    = irq_en;
      w[11:8]          = port;
      w[31:16]         = mask;
      return w;
   endfunction

   // called at a rising edge; returns at the edge that accepted the request
   task automatic send_request(op_type op, logic [31:0] w, logic level);
      int      gap;
      req_type r;
      r.operation  = op;
      r.write_data = w;
      r.line_level = level;
      gap = pick_gap(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      master_model.take_request(r);
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      while (master_model.pending() != 0)
         @(posedge clock);
   endtask

   // idle clocks with random line levels until the running bus cycle is over
   task automatic finish_bus_cycle();
      while (master_model.busy)
         send_request(OP_IDLE, $urandom, 1'($urandom_range(0, 1)));
   endtask

   task automatic run_cycle(logic [31:0] w);
      send_request(OP_WRITE, w, 1'($urandom_range(0, 1)));
      send_request(OP_READ, $urandom, 1'($urandom_range(0, 1)));
      finish_bus_cycle();
      send_request(OP_READ, $urandom, 1'($urandom_range(0, 1)));
   endtask

   task automatic configure(reg_set_type vals);
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= csr_index_type'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         master_model.set_register(csr_index_type'(i), vals[i]);
      end
      csr_we <= 1'b0;
   endtask

   function automatic reg_set_type random_regs();
      reg_set_type v;
      int          rtot, stot;
      rtot = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 24);
      stot = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 24);
      v[CSR_DIV_NORMAL]    = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(4, 12))
                                                        : 16'($urandom_range(0, 3));
      v[CSR_DIV_OVERDRIVE] = 16'($urandom_range(0, 3));
      v[CSR_RESET_LOW]     = {8'($urandom), 8'($urandom_range(0, rtot + 1))};
      v[CSR_PRESENCE]      = {8'($urandom), 8'($urandom_range(0, rtot + 2))};
      v[CSR_RESET_TOTAL]   = {8'($urandom), 8'(rtot)};
      v[CSR_SLOT_LOW_ONE]  = {8'($urandom), 8'($urandom_range(0, stot + 1))};
      v[CSR_SLOT_SAMPLE]   = {8'($urandom), 8'($urandom_range(0, stot + 2))};
      v[CSR_SLOT_TOTAL]    = {8'($urandom), 8'(stot)};
      return v;
   endfunction

   task automatic random_request();
      int          roll;
      op_type      op;
      logic [31:0] w;
      roll = $urandom_range(0, 99);
      w = $urandom;
      if (roll < 35)
         op = OP_IDLE;
      else if (roll < 60)
         op = OP_READ;
      else if (roll < 95)
         op = OP_WRITE;
      else
         op = OP_NOP;
      if (speed_pick == SPEED_OVERDRIVE)
         w[CTL_OVERDRIVE] = 1'b1;
      else if (speed_pick == SPEED_NORMAL)
         w[CTL_OVERDRIVE] = 1'b0;
      send_request(op, w, 1'($urandom_range(0, 1)));
   endtask

   // response side
   initial begin : response_sink
      int      gap;
      rsp_type got;
      forever begin
         gap = pick_gap(sink_calm);
         if (hold_off_wanted && !hold_off_done) begin
            gap = HOLD_OFF_CYCLES;
            hold_off_done = 1'b1;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(negedge clock); while (!rsp_valid);
         got = rsp_data;
         @(posedge clock);
         master_model.check_response(got);
      end
   end

   always @(negedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no request or response moved for %0d cycles", idle_cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : stimulus
      reg_set_type regs;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset value of the control register, read back around writes that leave the start bit clear
      send_request(OP_READ, 32'hFFFF_FFFF, 1'b1);
      send_request(OP_NOP, 32'hFFFF_FFFF, 1'b1);
      send_request(OP_WRITE, ~ctl_word(0, 0, 0, 1, 0, 0, 4'h0, 16'h0), 1'b0);
      send_request(OP_READ, '0, 1'b0);
      send_request(OP_WRITE, '0, 1'b1);
      send_request(OP_READ, '0, 1'b0);
      wait_results();
      // fast prescaler, tick counts left at their reset values
      regs = '{16'h0002, 16'h0001, {8'h00, RESET_LOW_RST}, {8'h00, PRESENCE_RST},
               {8'h00, RESET_TOTAL_RST}, {8'h00, SLOT_LOW_ONE_RST},
               {8'h00, SLOT_SAMPLE_RST}, {8'h00, SLOT_TOTAL_RST}};
      configure(regs);
      // write-1 slot in overdrive; writes while busy are dropped
      send_request(OP_WRITE, ctl_word(1, 0, 1, 1, 1, 1, 4'h5, 16'h8001), 1'b0);
      send_request(OP_WRITE, 32'hFFFF_FFFF, 1'b1);
      run_cycle(ctl_word(0, 1, 0, 1, 0, 0, 4'hA, 16'h0));
      // presence cycle in overdrive, then a normal-speed write-0 slot
      run_cycle(ctl_word(0, 1, 1, 1, 1, 1, 4'h3, 16'hA5A5));
      run_cycle(ctl_word(0, 0, 0, 1, 0, 1, 4'hF, 16'h5A5A));
      send_request(OP_READ, '0, 1'b1);
      wait_results();

      // zero dividers, one-tick slot, sample past the end, two-tick reset
      regs = '{16'h0000, 16'h0000, 16'h0100, 16'h00FF, 16'h0002, 16'h00FF,
               16'h0000, 16'h0001};
      configure(regs);
      run_cycle(ctl_word(1, 0, 0, 1, 0, 1, 4'h1, 16'h0));
      run_cycle(ctl_word(0, 0, 1, 1, 1, 1, 4'h2, 16'hFFFF));
      run_cycle(ctl_word(0, 1, 0, 1, 0, 1, 4'h7, 16'h0));
      wait_results();
      // zero-length slot
      regs = '{16'h0001, 16'h0002, 16'h0001, 16'h0001, 16'h0002, 16'h0001,
               16'h0001, 16'hAB00};
      configure(regs);
      run_cycle(ctl_word(1, 0, 0, 1, 0, 1, 4'h9, 16'h0));
      run_cycle(ctl_word(0, 0, 0, 1, 0, 0, 4'h9, 16'h0));
      run_cycle(ctl_word(1, 1, 1, 1, 1, 1, 4'hC, 16'h1234));

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         finish_bus_cycle();
         wait_results();
         case (ph)
            3: begin
               regs = '{16'hFFFF, 16'h0001, 16'h00FF, 16'h00FE, 16'h00FF, 16'h00FF,
                        16'h00FE, 16'h00FF};
               speed_pick = SPEED_OVERDRIVE;
            end
            6: begin
               regs = '{16'h0001, 16'hFFFF, 16'h00C8, 16'h0003, 16'h00FF, 16'h0001,
                        16'h00FF, 16'h00FF};
               speed_pick = SPEED_NORMAL;
            end
            default: begin
               regs = random_regs();
               speed_pick = SPEED_ANY;
            end
         endcase
         configure(regs);
         // the response side stalls long enough to back the requests up
         if (ph == 2)
            hold_off_wanted = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2)
               wait_results();
            random_request();
         end
      end

      wait_results();
      repeat (4) @(posedge clock);
      if (master_model.errors == 0 && master_model.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
